[rtl/multi_mode_led_controller_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the LED mode controller
// Shared property forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef MULTI_MODE_LED_CONTROLLER_ASSERT_SVH
`define MULTI_MODE_LED_CONTROLLER_ASSERT_SVH

// a, then c on the next edge; off while in reset
`define MMLC_ASSERT_NEXT(name, ck, rs, a, c, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) else $error(msg);

// a implies c on the same edge; off while in reset
`define MMLC_ASSERT_SAME(name, ck, rs, a, c, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) else $error(msg);

// a, then c on the next edge; always checked, reset included
`define MMLC_ASSERT_NEXT_ALWAYS(name, ck, a, c, msg) \
  name: assert property (@(posedge ck) (a) |=> (c)) else $error(msg);

`endif

[rtl/mmlc_pkg.sv]
// ---------------------------------------------------------------------------
// mmlc_pkg
// Types, codes and reset values shared by the LED mode controller.
// ---------------------------------------------------------------------------
`default_nettype none

package mmlc_pkg;

  // mode codes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_BLINK = 2'd1;
  localparam logic [1:0] MODE_BOTH  = 2'd2;
  localparam logic [1:0] MODE_FADE  = 2'd3;

  localparam logic [7:0] DUTY_FULL = 8'hFF;
  localparam logic [7:0] COUNT_MAX = 8'hFF;
  localparam logic [15:0] BLINK_MAX = 16'hFFFF;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_BLINK    = 2'd1;
  localparam logic [1:0] REG_FADE     = 2'd2;
  localparam logic [1:0] REG_TOP      = 2'd3;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd25;
  localparam logic [15:0] BLINK_RST    = 16'd400;
  localparam logic [7:0]  FADE_RST     = 8'd20;
  localparam logic [7:0]  TOP_RST      = 8'd180;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_PRESS,
    EV_RELEASE
  } btn_ev_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] blink_ticks;
    logic [7:0]  fade_ticks;
    logic [7:0]  fade_top;
  } cfg_t;

  typedef struct packed {
    logic [7:0] led1_duty;
    logic [7:0] led2_duty;
    logic       led3_on;
    logic [1:0] current_mode;
    logic       display_update;
  } res_t;

endpackage

`default_nettype wire

[rtl/mmlc_if.sv]
// ---------------------------------------------------------------------------
// mmlc_if
// Valid/ready channels for button ticks and LED result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface mmlc_in_if;
  logic valid;
  logic ready;
  logic mode_button_level;
  logic reset_button_level;

  modport source (output valid, output mode_button_level, output reset_button_level,
                  input ready);
  modport sink (input valid, input mode_button_level, input reset_button_level,
                output ready);
endinterface

interface mmlc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] led1_duty;
  logic [7:0] led2_duty;
  logic       led3_on;
  logic [1:0] current_mode;
  logic       display_update;

  modport source (output valid, output led1_duty, output led2_duty, output led3_on,
                  output current_mode, output display_update, input ready);
  modport sink (input valid, input led1_duty, input led2_duty, input led3_on,
                input current_mode, input display_update, output ready);
endinterface

`default_nettype wire

[rtl/multi_mode_led_controller.sv]
// ---------------------------------------------------------------------------
// multi_mode_led_controller
// Two debounced buttons step an LED controller through four display modes.
// ---------------------------------------------------------------------------
// Usage:
//   in_word  : one word per millisecond tick, carrying the raw active-low
//              mode and reset button levels.
//   out_word : one word per input word: LED1/LED2 duties, LED3 level, the
//              current mode and a display update flag.
//   APB port : four 32-bit registers at byte offsets 0x0, 0x4, 0x8, 0xC
//              (debounce, blink interval, fade interval, fade peak). Write
//              them only while no tick is in flight. pready is tied high.
// The word accepted at an edge shows on out_word from the next cycle.
// Throughput is one word per cycle unless the receiver stalls; the single
// result register is reloaded in the cycle it is taken, so in_word.ready is
// low only while a result sits unclaimed and out_word.ready is low.
// Reset (rst, synchronous) restores register defaults, mode off, LEDs dark
// and both buttons released, and empties the result register.
// A stalled receiver holds the result word steady and stalls the input.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_mode_led_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  mmlc_in_if.sink          in_word,
  mmlc_out_if.source       out_word,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  mmlc_pkg::cfg_t    cfg;
  mmlc_pkg::btn_ev_t mode_ev;
  mmlc_pkg::btn_ev_t reset_ev;
  mmlc_pkg::res_t    res_comb;
  mmlc_pkg::res_t    res_reg;
  logic              res_valid;
  logic              in_take;
  logic              cfg_wr;

  // ---- configuration registers ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= mmlc_pkg::DEBOUNCE_RST;
      cfg.blink_ticks    <= mmlc_pkg::BLINK_RST;
      cfg.fade_ticks     <= mmlc_pkg::FADE_RST;
      cfg.fade_top       <= mmlc_pkg::TOP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mmlc_pkg::REG_DEBOUNCE: cfg.debounce_ticks <= pwdata[7:0];
        mmlc_pkg::REG_BLINK:    cfg.blink_ticks    <= pwdata[15:0];
        mmlc_pkg::REG_FADE:     cfg.fade_ticks     <= pwdata[7:0];
        mmlc_pkg::REG_TOP:      cfg.fade_top       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mmlc_pkg::REG_DEBOUNCE: prdata = {24'd0, cfg.debounce_ticks};
      mmlc_pkg::REG_BLINK:    prdata = {16'd0, cfg.blink_ticks};
      mmlc_pkg::REG_FADE:     prdata = {24'd0, cfg.fade_ticks};
      mmlc_pkg::REG_TOP:      prdata = {24'd0, cfg.fade_top};
      default:                prdata = '0;
    endcase
  end

  // ---- input handshake: take a word whenever the result slot frees up ----
  assign in_word.ready = !res_valid || out_word.ready;
  assign in_take       = in_word.valid && in_word.ready;

  // ---- button debouncers; state advances only on accepted ticks ----
  mmlc_debounce u_mode_btn (
    .clk            (clk),
    .rst            (rst),
    .step           (in_take),
    .level          (in_word.mode_button_level),
    .debounce_ticks (cfg.debounce_ticks),
    .ev             (mode_ev)
  );

  mmlc_debounce u_reset_btn (
    .clk            (clk),
    .rst            (rst),
    .step           (in_take),
    .level          (in_word.reset_button_level),
    .debounce_ticks (cfg.debounce_ticks),
    .ev             (reset_ev)
  );

  // ---- mode / LED sequencing ----
  mmlc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (in_take),
    .mode_ev  (mode_ev),
    .reset_ev (reset_ev),
    .cfg      (cfg),
    .res      (res_comb)
  );

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_take) begin
      res_valid <= 1'b1;
    end else if (out_word.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_reg <= res_comb;
    end
  end

  assign out_word.valid          = res_valid;
  assign out_word.led1_duty      = res_reg.led1_duty;
  assign out_word.led2_duty      = res_reg.led2_duty;
  assign out_word.led3_on        = res_reg.led3_on;
  assign out_word.current_mode   = res_reg.current_mode;
  assign out_word.display_update = res_reg.display_update;

endmodule

`default_nettype wire

[rtl/mmlc_debounce.sv]
// ---------------------------------------------------------------------------
// mmlc_debounce
// One active-low button: stable counter, latch, press/release event.
// ---------------------------------------------------------------------------
`default_nettype none

module mmlc_debounce (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic            level,
  input  wire logic [7:0]      debounce_ticks,
  output mmlc_pkg::btn_ev_t    ev
);

  logic       prev_level;
  logic [7:0] stable_count;
  logic       latched;

  logic [7:0] stable_count_next;
  logic       latched_next;

  always_comb begin
    if (level != prev_level) begin
      stable_count_next = '0;
    end else if (stable_count < mmlc_pkg::COUNT_MAX) begin
      stable_count_next = stable_count + 8'd1;
    end else begin
      stable_count_next = stable_count;
    end

    ev           = mmlc_pkg::EV_NONE;
    latched_next = latched;
    if (stable_count_next > debounce_ticks) begin
      if (!level && !latched) begin
        latched_next = 1'b1;
        ev           = mmlc_pkg::EV_PRESS;
      end else if (level) begin
        latched_next = 1'b0;
        ev           = mmlc_pkg::EV_RELEASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level   <= 1'b1;
      stable_count <= '0;
      latched      <= 1'b0;
    end else if (step) begin
      prev_level   <= level;
      stable_count <= stable_count_next;
      latched      <= latched_next;
    end
  end

endmodule

`default_nettype wire

[rtl/mmlc_core.sv]
// ---------------------------------------------------------------------------
// mmlc_core
// Mode register, blink and fade sequencers, LED levels for one tick.
// ---------------------------------------------------------------------------
`default_nettype none

module mmlc_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire mmlc_pkg::btn_ev_t mode_ev,
  input  wire mmlc_pkg::btn_ev_t reset_ev,
  input  wire mmlc_pkg::cfg_t    cfg,
  output mmlc_pkg::res_t         res
);

  logic [1:0]  mode_reg;
  logic [15:0] blink_count;
  logic        blink_phase;
  logic [7:0]  fade_level;
  logic        fade_rising;
  logic [7:0]  fade_count;
  logic [7:0]  led1_level;
  logic [7:0]  led2_level;
  logic        led3_level;

  logic [1:0]  mode_reg_next;
  logic [15:0] blink_count_next;
  logic        blink_phase_next;
  logic [7:0]  fade_level_next;
  logic        fade_rising_next;
  logic [7:0]  fade_count_next;
  logic [7:0]  led1_level_next;
  logic [7:0]  led2_level_next;
  logic        led3_level_next;
  logic        disp;

  logic signed [9:0] fade_v;
  logic signed [9:0] top_s;
  logic [7:0]        period;
  logic [8:0]        fade_count_inc;

  always_comb begin
    mode_reg_next    = mode_reg;
    blink_phase_next = blink_phase;
    fade_level_next  = fade_level;
    fade_rising_next = fade_rising;
    fade_count_next  = fade_count;
    led1_level_next  = led1_level;
    led2_level_next  = led2_level;
    led3_level_next  = led3_level;
    disp             = 1'b0;
    fade_v           = '0;
    top_s            = $signed({2'b00, cfg.fade_top});
    period           = (cfg.fade_ticks == 8'd0) ? 8'd1 : cfg.fade_ticks;
    fade_count_inc   = '0;

    // elapsed count saturates
    blink_count_next = (blink_count < mmlc_pkg::BLINK_MAX) ? blink_count + 16'd1 : blink_count;

    // mode button
    if (mode_ev == mmlc_pkg::EV_PRESS) begin
      led3_level_next = 1'b1;
      mode_reg_next   = mode_reg + 2'd1;
      disp            = 1'b1;
      case (mode_reg_next)
        mmlc_pkg::MODE_OFF: begin
          led1_level_next = '0;
          led2_level_next = '0;
          led3_level_next = 1'b0;
        end
        mmlc_pkg::MODE_BLINK: begin
          led1_level_next  = '0;
          led2_level_next  = '0;
          led3_level_next  = 1'b0;
          blink_count_next = '0;
        end
        mmlc_pkg::MODE_BOTH: begin
          led1_level_next = mmlc_pkg::DUTY_FULL;
          led2_level_next = mmlc_pkg::DUTY_FULL;
          led3_level_next = 1'b1;
        end
        default: begin
          fade_level_next  = '0;
          fade_rising_next = 1'b1;
          fade_count_next  = '0;
        end
      endcase
    end else if (mode_ev == mmlc_pkg::EV_RELEASE) begin
      led3_level_next = 1'b0;
    end

    // reset button wins over a same-tick mode press
    if (reset_ev == mmlc_pkg::EV_PRESS) begin
      mode_reg_next   = mmlc_pkg::MODE_OFF;
      led1_level_next = '0;
      led2_level_next = '0;
      led3_level_next = 1'b0;
      disp            = 1'b1;
    end else if (reset_ev == mmlc_pkg::EV_RELEASE) begin
      led3_level_next = 1'b0;
    end

    // per-mode LED behavior
    if (mode_reg_next == mmlc_pkg::MODE_BLINK) begin
      if (blink_count_next >= cfg.blink_ticks) begin
        blink_count_next = '0;
        blink_phase_next = ~blink_phase_next;
        led1_level_next  = blink_phase_next ? mmlc_pkg::DUTY_FULL : 8'd0;
        led2_level_next  = blink_phase_next ? 8'd0 : mmlc_pkg::DUTY_FULL;
        led3_level_next  = 1'b0;
      end
    end else if (mode_reg_next == mmlc_pkg::MODE_FADE) begin
      if (fade_count_next == 8'd0) begin
        fade_v = fade_rising_next ? $signed({2'b00, fade_level_next}) + 10'sd1
                                  : $signed({2'b00, fade_level_next}) - 10'sd1;
        if (fade_v >= top_s) begin
          fade_v           = top_s;
          fade_rising_next = 1'b0;
        end
        if (fade_v <= 10'sd0) begin
          fade_v           = 10'sd0;
          fade_rising_next = 1'b1;
        end
        fade_level_next = fade_v[7:0];
        led1_level_next = fade_v[7:0];
        led2_level_next = fade_v[7:0];
        led3_level_next = 1'b0;
      end
      fade_count_inc = {1'b0, fade_count_next} + 9'd1;
      fade_count_next = (fade_count_inc >= {1'b0, period}) ? 8'd0 : fade_count_inc[7:0];
    end

    res.led1_duty      = led1_level_next;
    res.led2_duty      = led2_level_next;
    res.led3_on        = led3_level_next;
    res.current_mode   = mode_reg_next;
    res.display_update = disp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= mmlc_pkg::MODE_OFF;
      blink_count <= '0;
      blink_phase <= 1'b0;
      fade_level  <= '0;
      fade_rising <= 1'b1;
      fade_count  <= '0;
      led1_level  <= '0;
      led2_level  <= '0;
      led3_level  <= 1'b0;
    end else if (step) begin
      mode_reg    <= mode_reg_next;
      blink_count <= blink_count_next;
      blink_phase <= blink_phase_next;
      fade_level  <= fade_level_next;
      fade_rising <= fade_rising_next;
      fade_count  <= fade_count_next;
      led1_level  <= led1_level_next;
      led2_level  <= led2_level_next;
      led3_level  <= led3_level_next;
    end
  end

endmodule

`default_nettype wire

[rtl/mmlc_checker.sv]
// ---------------------------------------------------------------------------
// mmlc_checker
// Port-level checks on the LED mode controller, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "multi_mode_led_controller_assert.svh"

module mmlc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] led1_duty,
  input wire logic [7:0] led2_duty,
  input wire logic [1:0] current_mode
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // every accepted tick yields a word on the next cycle
  `MMLC_ASSERT_NEXT(a_tick_to_word, clk, rst, in_acc, out_valid, "accepted tick gave no word")

  // reset empties the result slot
  `MMLC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "word valid after reset")

  // off mode always shows both LEDs dark
  `MMLC_ASSERT_SAME(a_off_dark, clk, rst, out_valid && (current_mode == mmlc_pkg::MODE_OFF),
                    (led1_duty == 8'd0) && (led2_duty == 8'd0), "LEDs lit in off mode")

  // a stalled word stays put
  `MMLC_ASSERT_NEXT(a_stall_hold, clk, rst, out_stall,
                    out_valid && $stable(led1_duty) && $stable(current_mode),
                    "stalled word changed")

endmodule

bind multi_mode_led_controller mmlc_checker u_mmlc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_word.valid),
  .in_ready     (in_word.ready),
  .out_valid    (out_word.valid),
  .out_ready    (out_word.ready),
  .led1_duty    (out_word.led1_duty),
  .led2_duty    (out_word.led2_duty),
  .current_mode (out_word.current_mode)
);

`default_nettype wire

[tb/sv/led_word_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_word_checker
// Watches the tick channel, the LED word channel and the register port. Keeps
// its own copy of the controller state, predicts one LED word per accepted
// tick and compares every accepted LED word field by field in order.
// ---------------------------------------------------------------------------
module led_word_checker (
  input  logic        clk,
  input  logic        rst,
  mmlc_in_if          in_ch,
  mmlc_out_if         out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          pending_words,
  output int          error_count
);

  localparam int MODE_BTN  = 0;
  localparam int RESET_BTN = 1;

  mmlc_pkg::cfg_t cfg;
  logic [1:0]  mode;
  logic        btn_prev    [2];
  logic        btn_latched [2];
  logic [7:0]  btn_count   [2];
  logic [15:0] blink_count;
  logic        blink_phase;
  logic [7:0]  fade_level;
  logic [7:0]  fade_count;
  logic        fade_rising;
  logic [7:0]  led1;
  logic [7:0]  led2;
  logic        led3;

  mmlc_pkg::res_t expected_words [$];
  int   mismatches = 0;
  int   queued = 0;

  assign error_count   = mismatches;
  assign pending_words = queued;

  task automatic report_mismatch(input string msg);
    $display("%0t ns  MISMATCH  %s", $time, msg);
    mismatches++;
  endtask

  function automatic void reset_model();
    cfg.debounce_ticks = mmlc_pkg::DEBOUNCE_RST;
    cfg.blink_ticks    = mmlc_pkg::BLINK_RST;
    cfg.fade_ticks     = mmlc_pkg::FADE_RST;
    cfg.fade_top       = mmlc_pkg::TOP_RST;
    mode = mmlc_pkg::MODE_OFF;
    for (int b = 0; b < 2; b++) begin
      btn_prev[b]    = 1'b1;
      btn_latched[b] = 1'b0;
      btn_count[b]   = '0;
    end
    blink_count = '0;
    blink_phase = 1'b0;
    fade_level  = '0;
    fade_count  = '0;
    fade_rising = 1'b1;
    led1 = '0;
    led2 = '0;
    led3 = 1'b0;
  endfunction

  function automatic void set_leds(input logic [7:0] duty, input logic ind);
    led1 = duty;
    led2 = duty;
    led3 = ind;
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      mmlc_pkg::REG_DEBOUNCE: return {24'd0, cfg.debounce_ticks};
      mmlc_pkg::REG_BLINK:    return {16'd0, cfg.blink_ticks};
      mmlc_pkg::REG_FADE:     return {24'd0, cfg.fade_ticks};
      default:                return {24'd0, cfg.fade_top};
    endcase
  endfunction

  function automatic void write_reg(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      mmlc_pkg::REG_DEBOUNCE: cfg.debounce_ticks = data[7:0];
      mmlc_pkg::REG_BLINK:    cfg.blink_ticks    = data[15:0];
      mmlc_pkg::REG_FADE:     cfg.fade_ticks     = data[7:0];
      default:                cfg.fade_top       = data[7:0];
    endcase
  endfunction

  // stable counter restarts on a level change, saturates otherwise
  function automatic mmlc_pkg::btn_ev_t debounce_btn(input int b, input logic level);
    mmlc_pkg::btn_ev_t ev;
    ev = mmlc_pkg::EV_NONE;
    if (level != btn_prev[b])
      btn_count[b] = '0;
    else if (btn_count[b] != mmlc_pkg::COUNT_MAX)
      btn_count[b] = btn_count[b] + 8'd1;
    if (btn_count[b] > cfg.debounce_ticks) begin
      if (!level && !btn_latched[b]) begin
        btn_latched[b] = 1'b1;
        ev = mmlc_pkg::EV_PRESS;
      end else if (level) begin
        btn_latched[b] = 1'b0;
        ev = mmlc_pkg::EV_RELEASE;
      end
    end
    btn_prev[b] = level;
    return ev;
  endfunction

  function automatic mmlc_pkg::res_t next_led_word(input logic mode_lvl,
                                                   input logic reset_lvl);
    mmlc_pkg::res_t    w;
    mmlc_pkg::btn_ev_t ev;
    logic    shown;
    int      v;
    int      period;
    shown = 1'b0;
    if (blink_count != mmlc_pkg::BLINK_MAX)
      blink_count = blink_count + 16'd1;

    ev = debounce_btn(MODE_BTN, mode_lvl);
    if (ev == mmlc_pkg::EV_PRESS) begin
      led3 = 1'b1;
      mode = mode + 2'd1;
      case (mode)
        mmlc_pkg::MODE_OFF:   set_leds(8'd0, 1'b0);
        mmlc_pkg::MODE_BLINK: begin
          set_leds(8'd0, 1'b0);
          blink_count = '0;
        end
        mmlc_pkg::MODE_BOTH:  set_leds(mmlc_pkg::DUTY_FULL, 1'b1);
        default: begin
          fade_level  = '0;
          fade_rising = 1'b1;
          fade_count  = '0;
        end
      endcase
      shown = 1'b1;
    end else if (ev == mmlc_pkg::EV_RELEASE) begin
      led3 = 1'b0;
    end

    // reset press lands after the mode step, so it wins
    ev = debounce_btn(RESET_BTN, reset_lvl);
    if (ev == mmlc_pkg::EV_PRESS) begin
      mode = mmlc_pkg::MODE_OFF;
      set_leds(8'd0, 1'b0);
      shown = 1'b1;
    end else if (ev == mmlc_pkg::EV_RELEASE) begin
      led3 = 1'b0;
    end

    if (mode == mmlc_pkg::MODE_BLINK) begin
      if (blink_count >= cfg.blink_ticks) begin
        blink_count = '0;
        blink_phase = !blink_phase;
        led1 = blink_phase ? mmlc_pkg::DUTY_FULL : 8'd0;
        led2 = blink_phase ? 8'd0 : mmlc_pkg::DUTY_FULL;
        led3 = 1'b0;
      end
    end else if (mode == mmlc_pkg::MODE_FADE) begin
      period = (cfg.fade_ticks == 8'd0) ? 1 : int'(cfg.fade_ticks);
      if (fade_count == 8'd0) begin
        v = int'(fade_level) + (fade_rising ? 1 : -1);
        if (v >= int'(cfg.fade_top)) begin
          v = int'(cfg.fade_top);
          fade_rising = 1'b0;
        end
        if (v <= 0) begin
          v = 0;
          fade_rising = 1'b1;
        end
        fade_level = v[7:0];
        set_leds(fade_level, 1'b0);
      end
      fade_count = fade_count + 8'd1;
      if (int'(fade_count) >= period)
        fade_count = '0;
    end

    w.led1_duty      = led1;
    w.led2_duty      = led2;
    w.led3_on        = led3;
    w.current_mode   = mode;
    w.display_update = shown;
    return w;
  endfunction

  always @(posedge clk) begin
    mmlc_pkg::res_t want;
    if (rst) begin
      reset_model();
      expected_words.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite)
          write_reg(paddr[3:2], pwdata);
        else if (prdata !== reg_value(paddr[3:2]))
          report_mismatch($sformatf("register read at 0x%0h got 0x%0h expected 0x%0h",
                                    paddr, prdata, reg_value(paddr[3:2])));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("LED word with no tick behind it");
        end else begin
          want = expected_words.pop_front();
          if (out_ch.led1_duty !== want.led1_duty)
            report_mismatch($sformatf("led1_duty got %0d expected %0d",
                                      out_ch.led1_duty, want.led1_duty));
          if (out_ch.led2_duty !== want.led2_duty)
            report_mismatch($sformatf("led2_duty got %0d expected %0d",
                                      out_ch.led2_duty, want.led2_duty));
          if (out_ch.led3_on !== want.led3_on)
            report_mismatch($sformatf("led3_on got %0b expected %0b",
                                      out_ch.led3_on, want.led3_on));
          if (out_ch.current_mode !== want.current_mode)
            report_mismatch($sformatf("current_mode got %0d expected %0d",
                                      out_ch.current_mode, want.current_mode));
          if (out_ch.display_update !== want.display_update)
            report_mismatch($sformatf("display_update got %0b expected %0b",
                                      out_ch.display_update, want.display_update));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_words.push_back(next_led_word(in_ch.mode_button_level,
                                               in_ch.reset_button_level));
    end
    queued <= expected_words.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives button ticks and register settings into the LED mode controller.
// A directed pass walks every mode, both buttons and the both-pressed case;
// random passes then push press/release sequences, short bounces and noise
// through several register settings, with random stalls on both channels.
// ---------------------------------------------------------------------------
module tb;

  // generous: well above the slowest legal run
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mmlc_in_if  in_ch ();
  mmlc_out_if out_ch ();

  int pending_words;
  int error_count;
  int cycle_count = 0;

  // no idling on either side once this is set (last part of the run)
  logic calm = 1'b0;

  // debounce currently programmed; sizes the press/release holds
  int unsigned cur_deb = 32'(mmlc_pkg::DEBOUNCE_RST);

  logic [1:0] reg_list [4] = '{mmlc_pkg::REG_DEBOUNCE, mmlc_pkg::REG_BLINK,
                               mmlc_pkg::REG_FADE, mmlc_pkg::REG_TOP};

  // directed ticks, {mode level, reset level}, run with debounce 0:
  // a level held for two ticks counts. Walks blink, both on, fade (peak 2),
  // wrap to off, a reset press, then both buttons at once.
  logic [1:0] directed_ticks [25] = '{
    2'b11, 2'b11,
    2'b01, 2'b01, 2'b01,
    2'b11, 2'b11,
    2'b01, 2'b01,
    2'b11, 2'b11,
    2'b01, 2'b01,
    2'b11, 2'b11, 2'b11,
    2'b01, 2'b01,
    2'b10, 2'b10,
    2'b11, 2'b11,
    2'b00, 2'b00,
    2'b11
  };

  multi_mode_led_controller DUT (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_ch),
    .out_word (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  led_word_checker word_check (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .pending_words (pending_words),
    .error_count   (error_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // LED word receiver: ready runs of random length broken by stalls of random
  // length. One assignment per edge.
  initial begin : word_sink
    int unsigned run_left;
    logic        stall;
    out_ch.ready = 1'b0;
    run_left = 0;
    stall = 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        stall = !stall && ($urandom_range(0, 2) != 0);
        if (stall)
          run_left = $urandom_range(1, 6);
        else if ($urandom_range(0, 7) == 0)
          run_left = $urandom_range(40, 120);   // long clean stretch
        else
          run_left = $urandom_range(1, 16);
      end
      run_left--;
      out_ch.ready <= !stall || calm;
    end
  end

  // One tick word. Valid stays high after the handshake so back-to-back
  // words need no second assignment in the same step; callers lower it.
  task automatic send_tick(input logic m, input logic r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.mode_button_level  <= m;
    in_ch.reset_button_level <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic hold_levels(input logic m, input logic r, input int unsigned n);
    repeat (n) send_tick(m, r);
  endtask

  // lower valid and wait until every LED word is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (2) @(posedge clk);
  endtask

  // APB setup + access; returning to idle before the task ends keeps back-to-back calls apart
  task automatic reg_access(input logic [1:0] idx, input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write all four registers while idle, then read them back
  task automatic set_config(input logic [7:0] deb, input logic [15:0] blk,
                            input logic [7:0] fad, input logic [7:0] peak);
    drain();
    reg_access(mmlc_pkg::REG_DEBOUNCE, 1'b1, {24'd0, deb});
    reg_access(mmlc_pkg::REG_BLINK,    1'b1, {16'd0, blk});
    reg_access(mmlc_pkg::REG_FADE,     1'b1, {24'd0, fad});
    reg_access(mmlc_pkg::REG_TOP,      1'b1, {24'd0, peak});
    foreach (reg_list[i])
      reg_access(reg_list[i], 1'b0, 32'd0);
    cur_deb = 32'(deb);
  endtask

  // Random press sequences. A level must be held debounce+2 ticks to count;
  // most holds are just long enough, some are bounces that must not count.
  task automatic run_random(input int unsigned budget);
    int unsigned sent;
    int unsigned settle;
    int unsigned kind;
    int unsigned len;
    int unsigned gap;
    sent = 0;
    settle = cur_deb + 2;
    while (sent < budget) begin
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0)
        len = $urandom_range(1, settle - 1);
      else
        len = settle + $urandom_range(0, 3);
      gap = settle + $urandom_range(0, 3);
      case (kind)
        0, 1, 2, 3, 4: begin
          hold_levels(1'b0, 1'b1, len);     // mode press
          hold_levels(1'b1, 1'b1, gap);
        end
        5: begin
          hold_levels(1'b1, 1'b0, len);     // reset press
          hold_levels(1'b1, 1'b1, gap);
        end
        6: begin
          hold_levels(1'b0, 1'b0, len);     // both at once
          hold_levels(1'b1, 1'b1, gap);
        end
        7: begin
          len = $urandom_range(1, 8);       // raw noise
          gap = 0;
          repeat (len) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        default: begin
          gap = 0;
          len = len + $urandom_range(0, 24); // released, lets blink/fade run
          hold_levels(1'b1, 1'b1, len);
        end
      endcase
      sent += len + gap;
    end
  endtask

  initial begin : stimulus
    rst                      = 1'b1;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    in_ch.valid              = 1'b0;
    in_ch.mode_button_level  = 1'b1;
    in_ch.reset_button_level = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of the registers
    foreach (reg_list[i])
      reg_access(reg_list[i], 1'b0, 32'd0);

    // directed walk, fastest settings and a tiny fade peak
    set_config(8'd0, 16'd1, 8'd1, 8'd2);
    foreach (directed_ticks[i])
      send_tick(directed_ticks[i][1], directed_ticks[i][0]);
    run_random(80);

    // full fade peak, one step per tick
    set_config(8'd0, 16'd1, 8'd1, 8'd255);
    run_random(120);

    // small peak after a tall one: level clamps and falls
    set_config(8'd2, 16'd3, 8'd3, 8'd7);
    run_random(150);

    // back to the reset values
    set_config(mmlc_pkg::DEBOUNCE_RST, mmlc_pkg::BLINK_RST, mmlc_pkg::FADE_RST,
               mmlc_pkg::TOP_RST);
    run_random(150);

    // upper extremes: buttons can never act
    set_config(mmlc_pkg::COUNT_MAX, mmlc_pkg::BLINK_MAX, 8'd255, 8'd255);
    run_random(260);

    repeat (3) begin
      set_config(8'($urandom_range(0, 6)), 16'($urandom_range(1, 12)),
                 8'($urandom_range(1, 4)), 8'($urandom_range(1, 255)));
      run_random(60);
    end

    // lower extremes, no idling on either side
    set_config(8'd0, 16'd1, 8'd1, 8'd1);
    calm = 1'b1;
    run_random(80);

    drain();
    repeat (4) @(posedge clk);
    if (error_count == 0 && pending_words == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/mmlc_pkg.sv
rtl/mmlc_if.sv
rtl/mmlc_debounce.sv
rtl/mmlc_core.sv
rtl/multi_mode_led_controller.sv
rtl/mmlc_checker.sv
tb/sv/led_word_checker.sv
tb/sv/tb.sv
